FILE: sv/gbg_pkg.sv
// glyph run block grouper: shared types, constants and the width decode
// no dependencies; used by glyph_run_block_grouper
package gbg_pkg;

  localparam int unsigned CodeW   = 21;
  localparam int unsigned LenW    = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned WidthW  = 2;
  localparam int unsigned OffsetW = 32;

  // hex text lengths of a double and a single width glyph
  localparam logic [LenW-1:0] LenDouble = 8'd64;
  localparam logic [LenW-1:0] LenSingle = 8'd32;

  localparam logic [WidthW-1:0] WidthNone   = 2'd0;
  localparam logic [WidthW-1:0] WidthSingle = 2'd1;
  localparam logic [WidthW-1:0] WidthDouble = 2'd2;

  // result queue: two records may enter per item, one leaves per cycle unless the output stalls
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [CodeW-1:0]   first_code;
    logic [OffsetW-1:0] byte_offset;
    logic [CountW-1:0]  glyph_count;
    logic [WidthW-1:0]  width;
    logic               overflow;
    logic               last;
  } block_rec_t;

  function automatic logic [WidthW-1:0] width_of(input logic [LenW-1:0] len);
    logic [WidthW-1:0] w;
    if (len == LenDouble) begin
      w = WidthDouble;
    end else if (len == LenSingle) begin
      w = WidthSingle;
    end else begin
      w = WidthNone;
    end
    return w;
  endfunction

endpackage

FILE: sv/glyph_run_block_grouper.sv
// Takes one sorted glyph descriptor per cycle. A descriptor can make up to two block records:
// the run it breaks and, with the final flag, the run it closes. Both go into a four-entry
// result queue that the output side drains one record per cycle while out_stall_i is low. The
// input is stalled while the queue holds more than two records. Sustained rate is one glyph per
// cycle while the output is not stalled and there is no more than one record per glyph on
// average. Records are written into the queue as their glyph is taken and are read out in order.
// top level: glyph run block grouper; depends on gbg_pkg
module glyph_run_block_grouper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gbg_pkg::CodeW-1:0]  code_point_i,
  input  logic [gbg_pkg::LenW-1:0]   hex_length_i,
  input  logic                       final_glyph_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gbg_pkg::CodeW-1:0]  run_first_code_o,
  output logic [gbg_pkg::OffsetW-1:0] run_byte_offset_o,
  output logic [gbg_pkg::CountW-1:0] run_glyph_count_o,
  output logic [gbg_pkg::WidthW-1:0] run_width_o,
  output logic                       count_overflow_o,
  output logic                       last_block_o
);

  // open run
  logic                        run_open_q, run_open_d;
  logic [gbg_pkg::CodeW-1:0]   first_q, first_d;
  logic [gbg_pkg::CountW-1:0]  count_q, count_d;
  logic [gbg_pkg::WidthW-1:0]  width_q, width_d;
  logic [gbg_pkg::OffsetW-1:0] offset_q, offset_d;
  logic                        ovf_q, ovf_d;

  // state after the glyph, before the final flush
  logic [gbg_pkg::CodeW-1:0]   mid_first;
  logic [gbg_pkg::CountW-1:0]  mid_count;
  logic [gbg_pkg::WidthW-1:0]  mid_width;
  logic [gbg_pkg::OffsetW-1:0] mid_offset;
  logic                        mid_ovf;

  logic                        accept, pop, push_brk, push_fin, extend;
  logic [gbg_pkg::WidthW-1:0]  in_width;
  logic [gbg_pkg::CodeW:0]     next_code;
  logic [gbg_pkg::OffsetW-1:0] run_bytes;
  gbg_pkg::block_rec_t         rec_brk, rec_fin;

  gbg_pkg::block_rec_t         q_mem [gbg_pkg::QDepth];
  logic [gbg_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_fin;
  logic [gbg_pkg::QCntW-1:0]   q_cnt_q, q_cnt_d;

  assign in_stall_o  = (q_cnt_q > gbg_pkg::QCntW'(gbg_pkg::QDepth - 2));
  assign out_valid_o = (q_cnt_q != '0);
  assign accept      = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;

  assign in_width  = gbg_pkg::width_of(hex_length_i);
  assign next_code = {1'b0, first_q} + {{(gbg_pkg::CodeW + 1 - gbg_pkg::CountW){1'b0}}, count_q};
  assign extend    = run_open_q && (width_q == in_width) && ({1'b0, code_point_i} == next_code);

  // bytes of the open run: count * 16 * width
  always_comb begin
    unique case (width_q)
      gbg_pkg::WidthDouble: run_bytes = {11'd0, count_q, 5'd0};
      gbg_pkg::WidthSingle: run_bytes = {12'd0, count_q, 4'd0};
      default:              run_bytes = '0;
    endcase
  end

  always_comb begin
    if (extend) begin
      mid_first  = first_q;
      mid_width  = width_q;
      mid_offset = offset_q;
      if (count_q == '1) begin
        mid_count = count_q;
        mid_ovf   = 1'b1;
      end else begin
        mid_count = count_q + gbg_pkg::CountW'(1);
        mid_ovf   = ovf_q;
      end
    end else begin
      mid_first  = code_point_i;
      mid_count  = gbg_pkg::CountW'(1);
      mid_width  = in_width;
      mid_offset = run_open_q ? (offset_q + run_bytes) : '0;
      mid_ovf    = 1'b0;
    end
  end

  always_comb begin
    run_open_d = run_open_q;
    first_d    = first_q;
    count_d    = count_q;
    width_d    = width_q;
    offset_d   = offset_q;
    ovf_d      = ovf_q;
    if (accept) begin
      if (final_glyph_i) begin
        run_open_d = 1'b0;
        first_d    = '0;
        count_d    = '0;
        width_d    = gbg_pkg::WidthNone;
        offset_d   = '0;
        ovf_d      = 1'b0;
      end else begin
        run_open_d = 1'b1;
        first_d    = mid_first;
        count_d    = mid_count;
        width_d    = mid_width;
        offset_d   = mid_offset;
        ovf_d      = mid_ovf;
      end
    end
  end

  assign rec_brk = '{first_code: first_q, byte_offset: offset_q, glyph_count: count_q,
                     width: width_q, overflow: ovf_q, last: 1'b0};
  assign rec_fin = '{first_code: mid_first, byte_offset: mid_offset, glyph_count: mid_count,
                     width: mid_width, overflow: mid_ovf, last: 1'b1};

  assign push_brk   = accept && !extend && run_open_q;
  assign push_fin   = accept && final_glyph_i;
  assign wr_ptr_fin = wr_ptr_q + gbg_pkg::QPtrW'(push_brk);
  assign wr_ptr_d   = wr_ptr_fin + gbg_pkg::QPtrW'(push_fin);
  assign rd_ptr_d   = rd_ptr_q + gbg_pkg::QPtrW'(pop);
  assign q_cnt_d    = q_cnt_q + gbg_pkg::QCntW'(push_brk) + gbg_pkg::QCntW'(push_fin)
                      - gbg_pkg::QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      first_q    <= '0;
      count_q    <= '0;
      width_q    <= gbg_pkg::WidthNone;
      offset_q   <= '0;
      ovf_q      <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      q_cnt_q    <= '0;
    end else begin
      run_open_q <= run_open_d;
      first_q    <= first_d;
      count_q    <= count_d;
      width_q    <= width_d;
      offset_q   <= offset_d;
      ovf_q      <= ovf_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      q_cnt_q    <= q_cnt_d;
    end
  end

  // record storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_brk) begin
      q_mem[wr_ptr_q] <= rec_brk;
    end
    if (push_fin) begin
      q_mem[wr_ptr_fin] <= rec_fin;
    end
  end

  assign run_first_code_o  = q_mem[rd_ptr_q].first_code;
  assign run_byte_offset_o = q_mem[rd_ptr_q].byte_offset;
  assign run_glyph_count_o = q_mem[rd_ptr_q].glyph_count;
  assign run_width_o       = q_mem[rd_ptr_q].width;
  assign count_overflow_o  = q_mem[rd_ptr_q].overflow;
  assign last_block_o      = q_mem[rd_ptr_q].last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= gbg_pkg::QCntW'(gbg_pkg::QDepth))
    else $error("result queue count beyond depth");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && final_glyph_i |=> !run_open_q && count_q == '0 && offset_q == '0)
    else $error("final glyph left a run open");

  a_glyph_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !final_glyph_i |=> run_open_q && count_q != '0)
    else $error("accepted glyph left no run open");

  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_open_q |-> count_q == '0 && !ovf_q)
    else $error("closed run holds a count");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gbg_pkg::QPtrW'(rd_ptr_q + gbg_pkg::QPtrW'(q_cnt_q)) == wr_ptr_q)
    else $error("queue pointers disagree with count");

endmodule
